@@ hw/rtl/assert_macros.svh @@
// Assertion shorthands shared by the front, queue and back RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/nrg_pkg.sv @@
package nrg_pkg;

  localparam int SAMPLE_W = 16;
  localparam int VOL_W = 7;
  localparam int STEP_W = 20;
  localparam int PHASE_W = 20;
  localparam int FRAC_BITS = 16;
  localparam int MAX_REPEAT = 16;
  localparam int QUEUE_DEPTH = 2;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W = 20;

  localparam logic [CFG_INDEX_W-1:0] REG_PHASE_STEP = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MONO_MODE = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_VOLUME = 2'd2;

  localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(1 << FRAC_BITS);
  localparam logic [VOL_W-1:0] VOL_RESET = VOL_W'(100);
  localparam logic [VOL_W-1:0] VOL_MAX = VOL_W'(100);

  localparam logic [PHASE_W-1:0] ONE_FRAME = PHASE_W'(1 << FRAC_BITS);
  localparam logic [STEP_W-1:0] MIN_STEP =
    STEP_W'(((1 << FRAC_BITS) + MAX_REPEAT - 1) / MAX_REPEAT);
  localparam int CNT_W = (MAX_REPEAT > 1) ? $clog2(MAX_REPEAT) : 1;

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sd32767;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = -16'sd32768;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left_sample;
    logic signed [SAMPLE_W-1:0] right_sample;
  } in_word_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] out_left;
    logic signed [SAMPLE_W-1:0] out_right;
    logic                       last_of_frame;
  } out_word_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left;
    logic signed [SAMPLE_W-1:0] right;
  } pair_t;

  typedef struct packed {
    logic [STEP_W-1:0] phase_step;
    logic              mono_mode;
    logic [VOL_W-1:0]  volume_percent;
  } cfg_t;

endpackage

@@ hw/rtl/nrg_front.sv @@
`include "assert_macros.svh"

module nrg_front (
  input  logic                clk,
  input  logic                rst,
  input  nrg_pkg::cfg_t       cfg,
  input  logic                in_valid,
  output logic                in_ready,
  input  nrg_pkg::in_word_t   in_word,
  output logic                push_valid,
  input  logic                push_ready,
  output nrg_pkg::pair_t      push_word
);

  localparam int PROD_W = nrg_pkg::SAMPLE_W + nrg_pkg::VOL_W;
  localparam int MAG_W = PROD_W - 1;
  localparam int RECIP_SHIFT = 29;
  localparam int RECIP_W = 23;
  localparam int RPROD_W = MAG_W + RECIP_W;
  localparam int QUOT_W = nrg_pkg::SAMPLE_W + 1;
  localparam logic [RECIP_W-1:0] RECIP_C = RECIP_W'(((1 << RECIP_SHIFT) + 99) / 100);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL = 2'd1;
  localparam logic [1:0] ST_RECIP = 2'd2;
  localparam logic [1:0] ST_PUSH = 2'd3;

  logic [1:0] state;
  logic signed [nrg_pkg::SAMPLE_W-1:0] smp_l, smp_r;
  logic [nrg_pkg::VOL_W-1:0] vol;
  logic signed [PROD_W-1:0] prod_l, prod_r;
  logic [QUOT_W-1:0] quot_l, quot_r;
  logic neg_l, neg_r;
  logic [MAG_W-1:0] mag_l, mag_r;
  logic [RPROD_W-1:0] rprod_l, rprod_r;
  logic signed [PROD_W-1:0] vol_s;

  function automatic logic signed [nrg_pkg::SAMPLE_W-1:0] saturate(
    input logic neg,
    input logic [QUOT_W-1:0] q
  );
    logic signed [QUOT_W-1:0] sq;
    sq = neg ? -$signed(q) : $signed(q);
    if (sq > QUOT_W'(nrg_pkg::SAMPLE_MAX)) begin
      return nrg_pkg::SAMPLE_MAX;
    end else if (sq < QUOT_W'(nrg_pkg::SAMPLE_MIN)) begin
      return nrg_pkg::SAMPLE_MIN;
    end
    return sq[nrg_pkg::SAMPLE_W-1:0];
  endfunction

  // The reciprocal is rounded up; for magnitudes below 2^22 the floor is exact.
  always_comb begin
    vol_s = $signed({{(PROD_W-nrg_pkg::VOL_W){1'b0}}, vol});
    mag_l = prod_l[PROD_W-1] ? MAG_W'(-prod_l) : MAG_W'(prod_l);
    mag_r = prod_r[PROD_W-1] ? MAG_W'(-prod_r) : MAG_W'(prod_r);
    rprod_l = RPROD_W'(mag_l) * RPROD_W'(RECIP_C);
    rprod_r = RPROD_W'(mag_r) * RPROD_W'(RECIP_C);
  end

  assign in_ready = (state == ST_IDLE);
  assign push_valid = (state == ST_PUSH);
  assign push_word.left = saturate(neg_l, quot_l);
  assign push_word.right = saturate(neg_r, quot_r);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            state <= ST_MUL;
          end
        end
        ST_MUL: state <= ST_RECIP;
        ST_RECIP: state <= ST_PUSH;
        ST_PUSH: begin
          if (push_ready) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      smp_l <= in_word.left_sample;
      smp_r <= cfg.mono_mode ? in_word.left_sample : in_word.right_sample;
      vol <= (cfg.volume_percent > nrg_pkg::VOL_MAX) ? nrg_pkg::VOL_MAX
                                                     : cfg.volume_percent;
    end
    if (state == ST_MUL) begin
      prod_l <= PROD_W'(smp_l) * vol_s;
      prod_r <= PROD_W'(smp_r) * vol_s;
    end
    if (state == ST_RECIP) begin
      quot_l <= rprod_l[RECIP_SHIFT +: QUOT_W];
      quot_r <= rprod_r[RECIP_SHIFT +: QUOT_W];
      neg_l <= prod_l[PROD_W-1];
      neg_r <= prod_r[PROD_W-1];
    end
  end

endmodule

@@ hw/rtl/nrg_queue.sv @@
`include "assert_macros.svh"

module nrg_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  nrg_pkg::pair_t push_word,
  output logic           pop_valid,
  input  logic           pop_ready,
  output nrg_pkg::pair_t pop_word
);

  localparam int PTR_W = $clog2(nrg_pkg::QUEUE_DEPTH);
  localparam int COUNT_W = $clog2(nrg_pkg::QUEUE_DEPTH + 1);

  nrg_pkg::pair_t entries [nrg_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [COUNT_W-1:0] count;
  logic push, pop;

  assign push_ready = (count != COUNT_W'(nrg_pkg::QUEUE_DEPTH));
  assign pop_valid = (count != '0);
  assign pop_word = entries[rd_ptr];
  assign push = push_valid && push_ready;
  assign pop = pop_valid && pop_ready;

  // The depth is a power of two, so the pointers wrap on their own.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + COUNT_W'(1);
      end else if (pop && !push) begin
        count <= count - COUNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_word;
    end
  end

  `ASSERT_NEXT(a_count_up, clk, rst, push && !pop, count == $past(count) + COUNT_W'(1), "Queue count did not follow a push.")

endmodule

@@ hw/rtl/nrg_back.sv @@
`include "assert_macros.svh"

module nrg_back (
  input  logic               clk,
  input  logic               rst,
  input  nrg_pkg::cfg_t      cfg,
  input  logic               pop_valid,
  output logic               pop_ready,
  input  nrg_pkg::pair_t     pop_word,
  output logic               out_valid,
  input  logic               out_ready,
  output nrg_pkg::out_word_t out_word
);

  localparam int SUM_W = nrg_pkg::PHASE_W + 1;

  logic busy;
  logic [nrg_pkg::PHASE_W-1:0] phase;
  logic [nrg_pkg::CNT_W-1:0] cnt;
  nrg_pkg::pair_t cur;
  logic [nrg_pkg::STEP_W-1:0] step_eff;
  logic [SUM_W-1:0] sum;
  logic load, last_flag;

  assign step_eff = (cfg.phase_step < nrg_pkg::MIN_STEP) ? nrg_pkg::MIN_STEP
                                                         : cfg.phase_step;
  assign sum = SUM_W'(phase) + SUM_W'(step_eff);
  assign load = busy && (!out_valid || out_ready);
  assign last_flag = (sum >= SUM_W'(nrg_pkg::ONE_FRAME)) ||
                     (cnt == nrg_pkg::CNT_W'(nrg_pkg::MAX_REPEAT - 1));
  assign pop_ready = !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      phase <= '0;
      cnt <= '0;
      out_valid <= 1'b0;
    end else begin
      if (pop_valid && pop_ready) begin
        if (phase >= nrg_pkg::ONE_FRAME) begin
          phase <= phase - nrg_pkg::ONE_FRAME;
        end else begin
          busy <= 1'b1;
          cnt <= '0;
        end
      end
      if (load) begin
        cnt <= cnt + nrg_pkg::CNT_W'(1);
        if (last_flag) begin
          busy <= 1'b0;
          phase <= nrg_pkg::PHASE_W'(sum - SUM_W'(nrg_pkg::ONE_FRAME));
        end else begin
          phase <= sum[nrg_pkg::PHASE_W-1:0];
        end
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop_valid && pop_ready) begin
      cur <= pop_word;
    end
    if (load) begin
      out_word.out_left <= cur.left;
      out_word.out_right <= cur.right;
      out_word.last_of_frame <= last_flag;
    end
  end

  `ASSERT_IMPLIES(a_busy_phase, clk, rst, busy, phase < nrg_pkg::ONE_FRAME, "Busy with a phase past one frame.")
  `ASSERT_NEXT(a_last_ends, clk, rst, load && last_flag, !busy && out_word.last_of_frame, "Last word did not end the frame.")

endmodule

@@ hw/rtl/nearest_resampler_with_gain_top.sv @@
// Channel  Handshake               Word
// in       in_valid / in_ready     in_word (left_sample, right_sample)
// out      out_valid / out_ready   out_word (out_left, out_right, last_of_frame)
// cfg      cfg_valid / cfg_ready   cfg_index, cfg_data
// Each input frame causes n = 0 to 16 output words.
// The front does the gain multiply and the divide by one hundred in its MUL and RECIP states.
// The back emits one output word per cycle while out_ready is high, and takes a new frame only when idle.
// Reset clears the phase, the queue and loads the register reset values.
// A two-entry queue lets the front take new frames while the back is stalled.

module nearest_resampler_with_gain_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  nrg_pkg::in_word_t                   in_word,
  output logic                                out_valid,
  input  logic                                out_ready,
  output nrg_pkg::out_word_t                  out_word,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [nrg_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [nrg_pkg::CFG_DATA_W-1:0]      cfg_data
);

  nrg_pkg::cfg_t cfg;
  logic q_push_valid, q_push_ready, q_pop_valid, q_pop_ready;
  nrg_pkg::pair_t q_push_word, q_pop_word;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.phase_step <= nrg_pkg::STEP_RESET;
      cfg.mono_mode <= 1'b0;
      cfg.volume_percent <= nrg_pkg::VOL_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        nrg_pkg::REG_PHASE_STEP: cfg.phase_step <= cfg_data[nrg_pkg::STEP_W-1:0];
        nrg_pkg::REG_MONO_MODE: cfg.mono_mode <= cfg_data[0];
        nrg_pkg::REG_VOLUME: cfg.volume_percent <= cfg_data[nrg_pkg::VOL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  nrg_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_word    (in_word),
    .push_valid (q_push_valid),
    .push_ready (q_push_ready),
    .push_word  (q_push_word)
  );

  nrg_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (q_push_valid),
    .push_ready (q_push_ready),
    .push_word  (q_push_word),
    .pop_valid  (q_pop_valid),
    .pop_ready  (q_pop_ready),
    .pop_word   (q_pop_word)
  );

  nrg_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .pop_valid  (q_pop_valid),
    .pop_ready  (q_pop_ready),
    .pop_word   (q_pop_word),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_word   (out_word)
  );

endmodule

@@ verif/tb.sv @@
module tb;
  import nrg_pkg::*;

  localparam int SETTLE_CYCLES = 64;
  localparam int RANDOM_FRAMES = 440;
  localparam int NUM_ROWS = 37;
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;

  typedef enum logic {ROW_FRAME, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t kind;
    logic [CFG_INDEX_W-1:0] idx;
    logic [CFG_DATA_W-1:0] data;
    logic signed [SAMPLE_W-1:0] l;
    logic signed [SAMPLE_W-1:0] r;
    bit typed;
    logic signed [SAMPLE_W-1:0] want_l;
    logic signed [SAMPLE_W-1:0] want_r;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_word_t in_word = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_word_t out_word;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  logic [STEP_W-1:0] step_reg = STEP_RESET;
  logic mono_reg = 1'b0;
  logic [VOL_W-1:0] gain_reg = VOL_RESET;
  int unsigned phase_acc = 0;

  out_word_t pending_out[$];
  out_word_t head_word;
  int mismatch_count = 0;

  stim_row_t plan [NUM_ROWS] = '{
    '{ROW_FRAME, REG_PHASE_STEP, 20'd0, 16'sh7FFF, 16'sh8000, 1'b1, 16'sh7FFF, 16'sh8000},
    '{ROW_FRAME, REG_PHASE_STEP, 20'd0, 16'sh8000, 16'sh7FFF, 1'b1, 16'sh8000, 16'sh7FFF},
    '{ROW_FRAME, REG_PHASE_STEP, 20'd0, 16'sd0, -16'sd1, 1'b1, 16'sd0, -16'sd1},
    '{ROW_CFG, REG_VOLUME, 20'd50, 16'sd0, 16'sd0, 1'b0, 16'sd0, 16'sd0},
    '{ROW_FRAME, REG_PHASE_STEP, 20'd0, 16'sh8000, 16'sh7FFF, 1'b1, -16'sd16384, 16'sd16383},
    '{ROW_FRAME, REG_PHASE_STEP, 20'd0, -16'sd3, 16'sd3, 1'b1, -16'sd1, 16'sd1},
    '{ROW_CFG, REG_VOLUME, 20'd0, 16'sd0, 16'sd0, 1'b0, 16'sd0, 16'sd0},
    '{ROW_FRAME, REG_PHASE_STEP, 20'd0, 16'sd12345, -16'sd12345, 1'b1, 16'sd0, 16'sd0},
    '{ROW_CFG, REG_VOLUME, 20'hFFF7F, 16'sd0, 16'sd0, 1'b0, 16'sd0, 16'sd0},
    '{ROW_FRAME, REG_PHASE_STEP, 20'd0, 16'sh7FFF, 16'sh8000, 1'b1, 16'sh7FFF, 16'sh8000},
    '{ROW_CFG, REG_MONO_MODE, 20'hFFFFF, 16'sd0, 16'sd0, 1'b0, 16'sd0, 16'sd0},
    '{ROW_FRAME, REG_PHASE_STEP, 20'd0, 16'sh8000, 16'sd5, 1'b1, 16'sh8000, 16'sh8000},
    '{ROW_CFG, REG_UNUSED, 20'd0, 16'sd0, 16'sd0, 1'b0, 16'sd0, 16'sd0},
    '{ROW_FRAME, REG_PHASE_STEP, 20'd0, 16'sd7, 16'sd9, 1'b1, 16'sd7, 16'sd7},
    '{ROW_CFG, REG_MONO_MODE, 20'hFFFFE, 16'sd0, 16'sd0, 1'b0, 16'sd0, 16'sd0},
    '{ROW_FRAME, REG_PHASE_STEP, 20'd0, 16'sd7, 16'sd9, 1'b1, 16'sd7, 16'sd9},
    '{ROW_CFG, REG_VOLUME, 20'd99, 16'sd0, 16'sd0, 1'b0, 16'sd0, 16'sd0},
    '{ROW_FRAME, REG_PHASE_STEP, 20'd0, 16'sh7FFF, 16'sh8000, 1'b1, 16'sd32439, -16'sd32440},
    '{ROW_CFG, REG_PHASE_STEP, 20'd0, 16'sd0, 16'sd0, 1'b0, 16'sd0, 16'sd0},
    '{ROW_FRAME, REG_PHASE_STEP, 20'd0, 16'sd100, -16'sd100, 1'b0, 16'sd0, 16'sd0},
    '{ROW_FRAME, REG_PHASE_STEP, 20'd0, -16'sd1, 16'sd1, 1'b0, 16'sd0, 16'sd0},
    '{ROW_CFG, REG_PHASE_STEP, 20'd4095, 16'sd0, 16'sd0, 1'b0, 16'sd0, 16'sd0},
    '{ROW_FRAME, REG_PHASE_STEP, 20'd0, 16'sh7FFF, 16'sd3, 1'b0, 16'sd0, 16'sd0},
    '{ROW_CFG, REG_PHASE_STEP, 20'd4097, 16'sd0, 16'sd0, 1'b0, 16'sd0, 16'sd0},
    '{ROW_FRAME, REG_PHASE_STEP, 20'd0, 16'sh8000, -16'sd2, 1'b0, 16'sd0, 16'sd0},
    '{ROW_CFG, REG_PHASE_STEP, 20'hFFFFF, 16'sd0, 16'sd0, 1'b0, 16'sd0, 16'sd0},
    '{ROW_FRAME, REG_PHASE_STEP, 20'd0, 16'sd1000, 16'sd2000, 1'b0, 16'sd0, 16'sd0},
    '{ROW_FRAME, REG_PHASE_STEP, 20'd0, 16'sd3000, 16'sd4000, 1'b0, 16'sd0, 16'sd0},
    '{ROW_FRAME, REG_PHASE_STEP, 20'd0, 16'sd5000, 16'sd6000, 1'b0, 16'sd0, 16'sd0},
    '{ROW_CFG, REG_PHASE_STEP, 20'd524288, 16'sd0, 16'sd0, 1'b0, 16'sd0, 16'sd0},
    '{ROW_FRAME, REG_PHASE_STEP, 20'd0, -16'sd7000, 16'sd8000, 1'b0, 16'sd0, 16'sd0},
    '{ROW_FRAME, REG_PHASE_STEP, 20'd0, -16'sd9000, 16'sd10000, 1'b0, 16'sd0, 16'sd0},
    '{ROW_CFG, REG_PHASE_STEP, 20'd32768, 16'sd0, 16'sd0, 1'b0, 16'sd0, 16'sd0},
    '{ROW_FRAME, REG_PHASE_STEP, 20'd0, 16'sd11, -16'sd12, 1'b0, 16'sd0, 16'sd0},
    '{ROW_CFG, REG_PHASE_STEP, 20'd71332, 16'sd0, 16'sd0, 1'b0, 16'sd0, 16'sd0},
    '{ROW_FRAME, REG_PHASE_STEP, 20'd0, 16'sd21, -16'sd22, 1'b0, 16'sd0, 16'sd0},
    '{ROW_FRAME, REG_PHASE_STEP, 20'd0, 16'sd31, -16'sd32, 1'b0, 16'sd0, 16'sd0}
  };

  nearest_resampler_with_gain_top uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_word(in_word),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_word(out_word),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic signed [SAMPLE_W-1:0] apply_gain(logic signed [SAMPLE_W-1:0] s,
                                                           int vol);
    int prod;
    prod = int'(s) * vol;
    prod = prod / 100;
    if (prod > 32767) prod = 32767;
    if (prod < -32768) prod = -32768;
    return prod[SAMPLE_W-1:0];
  endfunction

  // Walks the output positions that fall inside one input frame.
  task automatic resample_frame(in_word_t w, bit record);
    int vol;
    int unsigned step_eff;
    int n;
    out_word_t o;
    vol = (gain_reg > VOL_MAX) ? int'(VOL_MAX) : int'(gain_reg);
    step_eff = (step_reg < MIN_STEP) ? 32'(MIN_STEP) : 32'(step_reg);
    o.out_left = apply_gain(w.left_sample, vol);
    o.out_right = apply_gain(mono_reg ? w.left_sample : w.right_sample, vol);
    n = 0;
    while (phase_acc < 32'(ONE_FRAME) && n < MAX_REPEAT) begin
      n++;
      phase_acc += step_eff;
      o.last_of_frame = !(phase_acc < 32'(ONE_FRAME) && n < MAX_REPEAT);
      if (record) pending_out.push_back(o);
    end
    if (phase_acc >= 32'(ONE_FRAME)) phase_acc -= 32'(ONE_FRAME);
    else phase_acc = 0;
  endtask

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic int ready_run();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 6);
    if (r < 90) return $urandom_range(8, 40);
    return $urandom_range(100, 300);
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    if ($urandom_range(0, 99) < 12) begin
      case ($urandom_range(0, 4))
        0: return 16'sh7FFF;
        1: return 16'sh8000;
        2: return 16'sd0;
        3: return -16'sd1;
        default: return 16'sd1;
      endcase
    end
    return SAMPLE_W'($urandom);
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_step();
    case ($urandom_range(0, 11))
      0: return '0;
      1: return CFG_DATA_W'($urandom_range(0, 32'(MIN_STEP) - 1));
      2: return MIN_STEP;
      3: return 20'd524288;
      4: return 20'hFFFFF;
      5: return CFG_DATA_W'($urandom);
      6, 7, 8: return CFG_DATA_W'($urandom_range(11000, 150000));
      default: return CFG_DATA_W'($urandom_range(4096, 524288));
    endcase
  endfunction

  function automatic logic [VOL_W-1:0] pick_volume();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return VOL_MAX;
      2: return 7'd127;
      3: return VOL_W'($urandom_range(101, 127));
      default: return VOL_W'($urandom_range(0, 100));
    endcase
  endfunction

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_out.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    wait_idle();
    cfg_index <= idx;
    cfg_data <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_PHASE_STEP: step_reg = data[STEP_W-1:0];
      REG_MONO_MODE: mono_reg = data[0];
      REG_VOLUME: gain_reg = data[VOL_W-1:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
  endtask

  task automatic send_frame(in_word_t w, bit typed, out_word_t want, int gap);
    in_word <= w;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    resample_frame(w, !typed);
    if (typed) pending_out.push_back(want);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic report_mismatch(string what, int want, int got);
    mismatch_count++;
    $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_out.size() == 0) begin
        report_mismatch("unexpected word, out_left", 0, int'(out_word.out_left));
      end else begin
        head_word = pending_out.pop_front();
        if (out_word.out_left !== head_word.out_left)
          report_mismatch("out_left", int'(head_word.out_left), int'(out_word.out_left));
        if (out_word.out_right !== head_word.out_right)
          report_mismatch("out_right", int'(head_word.out_right), int'(out_word.out_right));
        if (out_word.last_of_frame !== head_word.last_of_frame)
          report_mismatch("last_of_frame", int'(head_word.last_of_frame),
                          int'(out_word.last_of_frame));
      end
    end
  end

  initial begin
    @(posedge clk);
    forever begin
      out_ready <= 1'b1;
      repeat (ready_run()) @(posedge clk);
      out_ready <= 1'b0;
      repeat (idle_len() + 1) @(posedge clk);
    end
  end

  initial begin
    in_word_t w;
    out_word_t want;
    logic [CFG_DATA_W-1:0] data;
    int sent;
    int burst;
    bit steady;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        set_reg(plan[i].idx, plan[i].data);
      end else begin
        w.left_sample = plan[i].l;
        w.right_sample = plan[i].r;
        want.out_left = plan[i].want_l;
        want.out_right = plan[i].want_r;
        want.last_of_frame = 1'b1;
        send_frame(w, plan[i].typed, want, idle_len());
      end
    end

    // Each setting change drains the block first, so the sender waits out all results.
    sent = 0;
    while (sent < RANDOM_FRAMES) begin
      set_reg(REG_PHASE_STEP, pick_step());
      set_reg(REG_MONO_MODE, CFG_DATA_W'($urandom));
      data = CFG_DATA_W'($urandom);
      data[VOL_W-1:0] = pick_volume();
      set_reg(REG_VOLUME, data);
      if ($urandom_range(0, 3) == 0) set_reg(REG_UNUSED, CFG_DATA_W'($urandom));
      steady = ($urandom_range(0, 3) == 0);
      burst = $urandom_range(8, 36);
      if (burst > RANDOM_FRAMES - sent) burst = RANDOM_FRAMES - sent;
      repeat (burst) begin
        w.left_sample = pick_sample();
        w.right_sample = pick_sample();
        send_frame(w, 1'b0, '0, steady ? 0 : idle_len());
        sent++;
      end
    end

    wait_idle();
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #12000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
